FILE: rtl/circular_deque_engine_assert.svh
// assertion macros shared by the deque checker
`ifndef CIRCULAR_DEQUE_ENGINE_ASSERT_SVH
`define CIRCULAR_DEQUE_ENGINE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define CDE_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define CDE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cde_pkg.sv
// types, constants and slot arithmetic shared by the deque engine
package cde_pkg;

    localparam int unsigned CNT_W          = 9;
    localparam int unsigned OP_W           = 3;
    localparam int unsigned IO_DATA_W      = 32;
    localparam int unsigned DEPTH_DEF      = 256;
    localparam int unsigned ELEM_WIDTH_DEF = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [CNT_W-1:0]     position;
        logic [IO_DATA_W-1:0] data_in;
        logic                 force_req;
    } in_item_t;

    typedef struct packed {
        logic                 ok;
        logic [IO_DATA_W-1:0] data_out;
        logic [CNT_W-1:0]     fill_count;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic walk;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic walk_req;
        logic walk_busy;
    } status_t;

    // effective capacity: zero acts as one, anything above the store depth as the depth
    function automatic logic [CNT_W-1:0] cap_clamp(logic [CNT_W-1:0] v, int unsigned depth);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (int'(v) > int'(depth)) begin
            r = CNT_W'(depth);
        end
        return r;
    endfunction

    // (base + idx) mod cap, base below cap and idx at most cap
    function automatic logic [CNT_W-1:0] slot_add(logic [CNT_W-1:0] base,
                                                  logic [CNT_W-1:0] idx,
                                                  logic [CNT_W-1:0] cap);
        logic [CNT_W:0] sum;
        sum = {1'b0, base} + {1'b0, idx};
        if (sum >= {1'b0, cap}) begin
            sum = sum - {1'b0, cap};
        end
        return sum[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] slot_inc(logic [CNT_W-1:0] base,
                                                  logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        r = base + CNT_W'(1);
        if (r == cap) begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] slot_dec(logic [CNT_W-1:0] base,
                                                  logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] r;
        if (base == '0) begin
            r = cap - CNT_W'(1);
        end else begin
            r = base - CNT_W'(1);
        end
        return r;
    endfunction

endpackage

FILE: rtl/cde_ctrl.sv
// sequencing state machine of the deque engine
module cde_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  cde_pkg::status_t  status,
    output cde_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = status.walk_req ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (!status.walk_busy) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

FILE: rtl/cde_datapath.sv
// element store, head and count registers, insert walk and result register
module cde_datapath #(
    parameter int unsigned DEPTH      = cde_pkg::DEPTH_DEF,
    parameter int unsigned ELEM_WIDTH = cde_pkg::ELEM_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cde_pkg::cmd_t               cmd,
    output cde_pkg::status_t            status,
    input  cde_pkg::in_item_t           s_item,
    input  logic                        cfg_wr_en,
    input  logic [cde_pkg::CNT_W-1:0]   cfg_wr_data,
    output cde_pkg::out_item_t          m_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = cde_pkg::CNT_W;

    logic [ELEM_WIDTH-1:0] store_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] rdata_reg;

    logic [CW-1:0] cap_reg, head_reg, head_next, count_reg, count_next;
    logic          res_ok_reg, res_ok_next, res_rd_reg, res_rd_next;

    logic                  ins_front_reg, ins_full_reg;
    logic [CW-1:0]         ins_pos_reg;
    logic [ELEM_WIDTH-1:0] ins_data_reg;
    logic [CW-1:0]         remain_reg, remain_next, k_reg, k_next, dst_reg, dst_next;
    logic                  pend_reg, pend_next;

    cde_pkg::out_item_t m_item_reg;

    // accept-side decode
    logic [CW-1:0] pos, idx_sel, slot_a, head_inc, head_dec;
    logic          full, empty, ins_ok, ins_front;
    logic [CW-1:0] ins_last, ins_remain, ins_k;
    logic          acc_ok, acc_rd, acc_wr, acc_use_rd;
    logic [CW-1:0] acc_slot, acc_head, acc_count;

    // walk and commit addressing
    logic [CW-1:0] walk_src, walk_dst, commit_base, commit_slot;
    logic          commit_wr;

    // store port
    logic                  mem_wr, mem_rd;
    logic [CW-1:0]         mem_wr_slot, mem_rd_slot;
    logic [ELEM_WIDTH-1:0] mem_wr_data, s_elem;

    assign pos      = s_item.position;
    assign full     = (count_reg >= cap_reg);
    assign empty    = (count_reg == '0);
    assign head_inc = cde_pkg::slot_inc(head_reg, cap_reg);
    assign head_dec = cde_pkg::slot_dec(head_reg, cap_reg);
    assign s_elem   = ELEM_WIDTH'(s_item.data_in);

    always_comb begin
        case (s_item.operation)
            cde_pkg::OP_PUSH_BACK: idx_sel = count_reg;
            cde_pkg::OP_POP_BACK:  idx_sel = count_reg - CW'(1);
            default:               idx_sel = pos;
        endcase
    end

    assign slot_a = cde_pkg::slot_add(head_reg, idx_sel, cap_reg);

    // insert planning: move the shorter side
    assign ins_ok     = (pos <= count_reg) && (!full || s_item.force_req);
    assign ins_front  = (pos < (count_reg - pos));
    assign ins_last   = full ? (count_reg - CW'(1)) : count_reg;
    assign ins_remain = ins_front ? pos : ((ins_last > pos) ? (ins_last - pos) : '0);
    assign ins_k      = ins_front ? '0 : (ins_last - CW'(1));

    assign status.walk_req  = (s_item.operation == cde_pkg::OP_INSERT) && ins_ok;
    assign status.walk_busy = (remain_reg != '0) || pend_reg;

    always_comb begin
        acc_ok     = 1'b0;
        acc_rd     = 1'b0;
        acc_wr     = 1'b0;
        acc_use_rd = 1'b0;
        acc_slot   = slot_a;
        acc_head   = head_reg;
        acc_count  = count_reg;
        case (s_item.operation)
            cde_pkg::OP_PUSH_FRONT: begin
                if (!full || s_item.force_req) begin
                    acc_ok    = 1'b1;
                    acc_wr    = 1'b1;
                    acc_slot  = head_dec;
                    acc_head  = head_dec;
                    acc_count = full ? count_reg : (count_reg + CW'(1));
                end
            end
            cde_pkg::OP_PUSH_BACK: begin
                if (!full) begin
                    acc_ok    = 1'b1;
                    acc_wr    = 1'b1;
                    acc_count = count_reg + CW'(1);
                end else if (s_item.force_req) begin
                    // overwrite the oldest element and move the front on
                    acc_ok   = 1'b1;
                    acc_wr   = 1'b1;
                    acc_slot = head_reg;
                    acc_head = head_inc;
                end
            end
            cde_pkg::OP_POP_FRONT: begin
                if (!empty) begin
                    acc_ok     = 1'b1;
                    acc_rd     = 1'b1;
                    acc_use_rd = 1'b1;
                    acc_slot   = head_reg;
                    acc_head   = head_inc;
                    acc_count  = count_reg - CW'(1);
                end
            end
            cde_pkg::OP_POP_BACK: begin
                if (!empty) begin
                    acc_ok     = 1'b1;
                    acc_rd     = 1'b1;
                    acc_use_rd = 1'b1;
                    acc_count  = count_reg - CW'(1);
                end
            end
            cde_pkg::OP_READ: begin
                if (pos < count_reg) begin
                    acc_ok     = 1'b1;
                    acc_rd     = 1'b1;
                    acc_use_rd = 1'b1;
                end
            end
            cde_pkg::OP_INSERT: begin
                acc_ok = ins_ok;
            end
            cde_pkg::OP_CLEAR: begin
                acc_ok    = 1'b1;
                acc_head  = '0;
                acc_count = '0;
            end
            default: begin
                acc_ok = 1'b0;
            end
        endcase
    end

    // walk moves one element per cycle, source read now, destination written next cycle
    assign walk_src = cde_pkg::slot_add(head_reg, k_reg, cap_reg);
    assign walk_dst = ins_front_reg ? cde_pkg::slot_dec(walk_src, cap_reg)
                                    : cde_pkg::slot_inc(walk_src, cap_reg);

    assign commit_base = ins_front_reg ? head_dec : head_reg;
    assign commit_slot = cde_pkg::slot_add(commit_base, ins_pos_reg, cap_reg);
    // a forced insert at the end of a full store drops the new element itself
    assign commit_wr   = ins_front_reg || (ins_pos_reg < cap_reg);

    always_comb begin
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        mem_wr_slot = acc_slot;
        mem_rd_slot = acc_slot;
        mem_wr_data = s_elem;
        if (cmd.accept) begin
            mem_wr = acc_wr;
            mem_rd = acc_rd;
        end else if (cmd.walk) begin
            mem_rd      = (remain_reg != '0);
            mem_rd_slot = walk_src;
            mem_wr      = pend_reg;
            mem_wr_slot = dst_reg;
            mem_wr_data = rdata_reg;
        end else if (cmd.commit) begin
            mem_wr      = commit_wr;
            mem_wr_slot = commit_slot;
            mem_wr_data = ins_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            store_mem[AW'(mem_wr_slot)] <= mem_wr_data;
        end
        if (mem_rd) begin
            rdata_reg <= store_mem[AW'(mem_rd_slot)];
        end
    end

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        res_ok_next = res_ok_reg;
        res_rd_next = res_rd_reg;
        remain_next = remain_reg;
        k_next      = k_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        if (cmd.accept) begin
            head_next   = acc_head;
            count_next  = acc_count;
            res_ok_next = acc_ok;
            res_rd_next = acc_use_rd;
            remain_next = status.walk_req ? ins_remain : '0;
            k_next      = ins_k;
            pend_next   = 1'b0;
        end else if (cmd.walk) begin
            if (remain_reg != '0) begin
                remain_next = remain_reg - CW'(1);
                k_next      = ins_front_reg ? (k_reg + CW'(1)) : (k_reg - CW'(1));
                dst_next    = walk_dst;
                pend_next   = 1'b1;
            end else begin
                pend_next = 1'b0;
            end
        end else if (cmd.commit) begin
            head_next  = commit_base;
            count_next = ins_full_reg ? count_reg : (count_reg + CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= cde_pkg::cap_clamp(cde_pkg::CAP_RESET, DEPTH);
            head_reg   <= '0;
            count_reg  <= '0;
            res_ok_reg <= 1'b0;
            res_rd_reg <= 1'b0;
            remain_reg <= '0;
            pend_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            cap_reg   <= cde_pkg::cap_clamp(cfg_wr_data, DEPTH);
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            res_ok_reg <= res_ok_next;
            res_rd_reg <= res_rd_next;
            remain_reg <= remain_next;
            pend_reg   <= pend_next;
        end
    end

    // insert operands and walk addresses
    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        dst_reg <= dst_next;
        if (cmd.accept) begin
            ins_front_reg <= ins_front;
            ins_full_reg  <= full;
            ins_pos_reg   <= pos;
            ins_data_reg  <= s_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_item_reg.ok         <= res_ok_reg;
            m_item_reg.data_out   <= res_rd_reg ? cde_pkg::IO_DATA_W'(rdata_reg) : '0;
            m_item_reg.fill_count <= count_reg;
        end
    end

    assign m_item = m_item_reg;

endmodule

FILE: rtl/circular_deque_engine.sv
// top level of the circular deque engine
//
//  port group        direction  handshake          payload
//  s_ (operations)   in         s_valid / s_ready  cde_pkg::in_item_t
//  m_ (results)      out        m_valid / m_ready  cde_pkg::out_item_t
//  cfg_ (capacity)   in         cfg_wr_en          cfg_wr_data, 9 bits
//
// push, pop, read, clear and refused operations run the accept with the store access,
// then the result register load
// insert runs the accept, the walk, the commit and the result load; the walk moves n elements
// (at most about half the fill), one element per cycle through the store's read port and write port
// reset clears head and count and sets the full capacity; the store needs no clearing pass
// a result waiting on m_ready holds its register and the block then stalls before the next load
module circular_deque_engine #(
    parameter int unsigned DEPTH      = cde_pkg::DEPTH_DEF,
    parameter int unsigned ELEM_WIDTH = cde_pkg::ELEM_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  cde_pkg::in_item_t         s_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output cde_pkg::out_item_t        m_item,
    input  logic                      cfg_wr_en,
    input  logic [cde_pkg::CNT_W-1:0] cfg_wr_data
);

    cde_pkg::cmd_t    cmd;
    cde_pkg::status_t status;

    cde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cde_datapath #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_item      (s_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_item      (m_item)
    );

endmodule

FILE: rtl/cde_checker.sv
// port-level checks on the deque engine, bound to the top level
`include "circular_deque_engine_assert.svh"

module cde_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cde_pkg::out_item_t m_item
);

    // a stalled result transaction keeps its payload
    `CDE_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")

    // a refused operation returns no element
    `CDE_ASSERT_SAME(a_refused_zero, aclk, aresetn, m_valid && !m_item.ok, m_item.data_out == '0, "refused result carries data")

    // one operation at a time: input closes after each accepted transaction
    `CDE_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "input open right after accept")

    // a result only appears after the block has been busy with an operation
    `CDE_ASSERT_SAME(a_result_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready), "result without preceding work")

endmodule

bind circular_deque_engine cde_checker u_cde_checker (.*);
